/* sv/scan_polar_to_cartesian_macros.svh */
// Assertion macros shared by the scan polar-to-Cartesian RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPC_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPC_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/spc_pkg.sv */
// Shared constants, types and CORDIC tables for the scan polar-to-Cartesian block.
// No dependencies.
package spc_pkg;

	localparam int RANGE_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;

	// config port
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_ANGLE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_STEP  = 1'd1;

	// CORDIC datapath, Q3.30 vectors, angles in 32-bit turn units
	localparam int CORDIC_STEPS = 30;
	localparam int XY_BITS      = 33;
	localparam int Z_BITS       = 32;
	localparam int TRIG_BITS    = 32;
	localparam int FRAC_BITS    = 30;

	localparam logic signed [XY_BITS-1:0]   X_INIT       = 33'sh0_26DD_3B6A;
	localparam logic signed [TRIG_BITS-1:0] TRIG_ONE     = 32'sh4000_0000;
	localparam logic signed [Z_BITS-1:0]    QUARTER_TURN = 32'sh4000_0000;

	localparam logic [Z_BITS-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// per-stage control carried down the chain
	typedef struct packed {
		logic valid;
		logic flip;
	} spc_ctl_t;

endpackage

/* sv/spc_in_if.sv */
// Input channel: one range sample word per handshake.
// No dependencies.
interface spc_in_if #(
	parameter int RANGE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_sample;
	logic                  first_of_scan;

	modport source (output valid, range_sample, first_of_scan, input ready);
	modport sink   (input valid, range_sample, first_of_scan, output ready);
endinterface

/* sv/spc_out_if.sv */
// Output channel: one Cartesian point word per handshake.
// No dependencies.
interface spc_out_if #(
	parameter int RANGE_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [RANGE_BITS:0] x_coord;
	logic signed [RANGE_BITS:0] y_coord;

	modport source (output valid, x_coord, y_coord, input ready);
	modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

/* sv/spc_angle.sv */
// Config registers, beam angle accumulator and CORDIC pre-rotation stage.
// Depends on spc_pkg and scan_polar_to_cartesian_macros.svh.
`include "scan_polar_to_cartesian_macros.svh"

module spc_angle #(
	parameter int RANGE_BITS = spc_pkg::RANGE_BITS_DEF,
	parameter int ANGLE_BITS = spc_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              accept,
	input  logic [RANGE_BITS-1:0]             range_sample,
	input  logic                              first_of_scan,
	input  logic                              wr_en,
	input  logic [spc_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [spc_pkg::CFG_BITS-1:0]      wr_data,
	output spc_pkg::spc_ctl_t                 ctl_s0,
	output logic [spc_pkg::Z_BITS-1:0]        z_s0,
	output logic [RANGE_BITS-1:0]             range_s0
);

	logic [ANGLE_BITS-1:0]          start_q;
	logic [ANGLE_BITS-1:0]          step_q;
	logic [ANGLE_BITS-1:0]          beam_q;
	logic [ANGLE_BITS-1:0]          ang;
	logic [ANGLE_BITS-1:0]          wr_angle;
	logic [spc_pkg::Z_BITS-1:0]     turn;
	logic                           flip;
	logic [spc_pkg::Z_BITS-1:0]     z_init;

	// 16-bit register value, sign extended then wrapped to the angle width
	assign wr_angle = ANGLE_BITS'($signed(wr_data));
	assign ang      = first_of_scan ? start_q : beam_q;

	// scale to 32 bits per turn; left half plane gets turned by half a turn
	assign turn   = spc_pkg::Z_BITS'(ang) << (spc_pkg::Z_BITS - ANGLE_BITS);
	assign flip   = turn[spc_pkg::Z_BITS-1] ^ turn[spc_pkg::Z_BITS-2];
	assign z_init = {turn[spc_pkg::Z_BITS-1] ^ flip, turn[spc_pkg::Z_BITS-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= '0;
			beam_q  <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					spc_pkg::REG_START_ANGLE: start_q <= wr_angle;
					spc_pkg::REG_ANGLE_STEP:  step_q  <= wr_angle;
					default: ;
				endcase
			end
			if (accept) begin
				beam_q <= ang + step_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (adv) begin
			ctl_s0.valid <= accept;
			ctl_s0.flip  <= flip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s0     <= z_init;
			range_s0 <= range_sample;
		end
	end

	`SPC_ASSERT_NXT(a_scan_restart, clk, arst_n, accept && first_of_scan,
		beam_q == $past(start_q + step_q), "beam angle not restarted from start angle")
	`SPC_ASSERT_IMP(a_z_in_right_half, clk, arst_n, ctl_s0.valid,
		($signed(z_s0) >= -spc_pkg::QUARTER_TURN) && ($signed(z_s0) < spc_pkg::QUARTER_TURN),
		"pre-rotated angle outside right half plane")

endmodule

/* sv/spc_cordic_cell.sv */
// One CORDIC rotation cell: a single micro-rotation by a fixed shift.
// Depends on spc_pkg.
module spc_cordic_cell #(
	parameter int RANGE_BITS = spc_pkg::RANGE_BITS_DEF,
	parameter int STEP       = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  spc_pkg::spc_ctl_t                  ctl_i,
	input  logic signed [spc_pkg::XY_BITS-1:0] x_i,
	input  logic signed [spc_pkg::XY_BITS-1:0] y_i,
	input  logic [spc_pkg::Z_BITS-1:0]         z_i,
	input  logic [RANGE_BITS-1:0]              range_i,
	output spc_pkg::spc_ctl_t                  ctl_s1,
	output logic signed [spc_pkg::XY_BITS-1:0] x_s1,
	output logic signed [spc_pkg::XY_BITS-1:0] y_s1,
	output logic [spc_pkg::Z_BITS-1:0]         z_s1,
	output logic [RANGE_BITS-1:0]              range_s1
);

	logic signed [spc_pkg::XY_BITS-1:0] x_sh;
	logic signed [spc_pkg::XY_BITS-1:0] y_sh;
	logic                               ccw;

	// floor shifts
	assign x_sh = x_i >>> STEP;
	assign y_sh = y_i >>> STEP;
	assign ccw  = !z_i[spc_pkg::Z_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ccw) begin
				x_s1 <= x_i - y_sh;
				y_s1 <= y_i + x_sh;
				z_s1 <= z_i - spc_pkg::ATAN_TURN[STEP];
			end else begin
				x_s1 <= x_i + y_sh;
				y_s1 <= y_i - x_sh;
				z_s1 <= z_i + spc_pkg::ATAN_TURN[STEP];
			end
			range_s1 <= range_i;
		end
	end

endmodule

/* sv/spc_scale.sv */
// Unflip and clamp of cos/sin, range multiply, round toward zero, output register.
// Depends on spc_pkg and scan_polar_to_cartesian_macros.svh.
`include "scan_polar_to_cartesian_macros.svh"

module spc_scale #(
	parameter int RANGE_BITS = spc_pkg::RANGE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  spc_pkg::spc_ctl_t                  ctl_i,
	input  logic signed [spc_pkg::XY_BITS-1:0] x_i,
	input  logic signed [spc_pkg::XY_BITS-1:0] y_i,
	input  logic [RANGE_BITS-1:0]              range_i,
	output logic                               out_valid_q,
	output logic signed [RANGE_BITS:0]         x_coord_q,
	output logic signed [RANGE_BITS:0]         y_coord_q
);

	localparam int PROD_BITS = RANGE_BITS + 1 + spc_pkg::TRIG_BITS;
	localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
		PROD_BITS'((64'd1 << spc_pkg::FRAC_BITS) - 64'd1);
	localparam logic signed [spc_pkg::XY_BITS-1:0] ONE_XY =
		spc_pkg::XY_BITS'(spc_pkg::TRIG_ONE);

	logic signed [spc_pkg::XY_BITS-1:0]   cos_raw;
	logic signed [spc_pkg::XY_BITS-1:0]   sin_raw;
	logic signed [spc_pkg::XY_BITS-1:0]   cos_clamp;
	logic signed [spc_pkg::XY_BITS-1:0]   sin_clamp;
	logic                                 v_s1;
	logic                                 v_s2;
	logic signed [spc_pkg::TRIG_BITS-1:0] cos_s1;
	logic signed [spc_pkg::TRIG_BITS-1:0] sin_s1;
	logic [RANGE_BITS-1:0]                range_s1;
	logic signed [RANGE_BITS:0]           range_ext;
	logic signed [PROD_BITS-1:0]          px_s2;
	logic signed [PROD_BITS-1:0]          py_s2;
	logic signed [PROD_BITS-1:0]          px_rnd;
	logic signed [PROD_BITS-1:0]          py_rnd;

	assign cos_raw = ctl_i.flip ? -x_i : x_i;
	assign sin_raw = ctl_i.flip ? -y_i : y_i;

	always_comb begin
		cos_clamp = cos_raw;
		if (cos_raw > ONE_XY) cos_clamp = ONE_XY;
		else if (cos_raw < -ONE_XY) cos_clamp = -ONE_XY;
		sin_clamp = sin_raw;
		if (sin_raw > ONE_XY) sin_clamp = ONE_XY;
		else if (sin_raw < -ONE_XY) sin_clamp = -ONE_XY;
	end

	assign range_ext = $signed({1'b0, range_s1});

	// negative products get a bias so the shift truncates toward zero
	assign px_rnd = (px_s2 + (px_s2[PROD_BITS-1] ? ROUND_BIAS : '0)) >>> spc_pkg::FRAC_BITS;
	assign py_rnd = (py_s2 + (py_s2[PROD_BITS-1] ? ROUND_BIAS : '0)) >>> spc_pkg::FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= ctl_i.valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1    <= spc_pkg::TRIG_BITS'(cos_clamp);
			sin_s1    <= spc_pkg::TRIG_BITS'(sin_clamp);
			range_s1  <= range_i;
			px_s2     <= range_ext * cos_s1;
			py_s2     <= range_ext * sin_s1;
			x_coord_q <= px_rnd[RANGE_BITS:0];
			y_coord_q <= py_rnd[RANGE_BITS:0];
		end
	end

	`SPC_ASSERT_IMP(a_cos_bounded, clk, arst_n, v_s1,
		(cos_s1 <= spc_pkg::TRIG_ONE) && (cos_s1 >= -spc_pkg::TRIG_ONE),
		"cosine outside unit range after clamp")
	`SPC_ASSERT_IMP(a_sin_bounded, clk, arst_n, v_s1,
		(sin_s1 <= spc_pkg::TRIG_ONE) && (sin_s1 >= -spc_pkg::TRIG_ONE),
		"sine outside unit range after clamp")

endmodule

/* sv/scan_polar_to_cartesian.sv */
// Top level: laser scan range samples to Cartesian points via a CORDIC cell chain.
// Depends on spc_pkg, spc_in_if, spc_out_if, spc_angle, spc_cordic_cell, spc_scale.
//
//  channel   dir  word                                handshake
//  samples   in   range_sample, first_of_scan         valid/ready
//  points    out  x_coord, y_coord (signed, R+1 bits) valid/ready
//  config    in   wr_index, wr_data                   wr_en, no back-pressure
//
// Throughput: one word per cycle while the chain is not stalled. Sample accept to point valid
//   runs through the entry stage, 30-cell CORDIC chain, clamp, multiply and output stages.
// Reset: arst_n clears config registers, the beam angle and every stage valid.
// Stall: the whole chain advances together; it freezes only while a point word sits
//   in the output register and points.ready is low, and samples.ready drops with it.
module scan_polar_to_cartesian #(
	parameter int RANGE_BITS = spc_pkg::RANGE_BITS_DEF,
	parameter int ANGLE_BITS = spc_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	spc_in_if.sink                           samples,
	spc_out_if.source                        points,
	input  logic                             wr_en,
	input  logic [spc_pkg::CFG_IDX_BITS-1:0] wr_index,
	input  logic [spc_pkg::CFG_BITS-1:0]     wr_data
);

	localparam int N = spc_pkg::CORDIC_STEPS;

	// chain taps: index 0 feeds the first cell, index N leaves the last
	spc_pkg::spc_ctl_t                  ctl_c   [N+1];
	logic signed [spc_pkg::XY_BITS-1:0] x_c     [N+1];
	logic signed [spc_pkg::XY_BITS-1:0] y_c     [N+1];
	logic [spc_pkg::Z_BITS-1:0]         z_c     [N+1];
	logic [RANGE_BITS-1:0]              range_c [N+1];

	logic adv;
	logic accept;
	logic out_valid;

	// global advance: move everything unless a finished word is stuck at the output
	assign adv           = !out_valid || points.ready;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;
	assign points.valid  = out_valid;

	spc_angle #(
		.RANGE_BITS (RANGE_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_angle (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.accept        (accept),
		.range_sample  (samples.range_sample),
		.first_of_scan (samples.first_of_scan),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.ctl_s0        (ctl_c[0]),
		.z_s0          (z_c[0]),
		.range_s0      (range_c[0])
	);

	// every rotation starts from the gain-compensated unit vector on the x axis
	assign x_c[0] = spc_pkg::X_INIT;
	assign y_c[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		spc_cordic_cell #(
			.RANGE_BITS (RANGE_BITS),
			.STEP       (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_i    (ctl_c[i]),
			.x_i      (x_c[i]),
			.y_i      (y_c[i]),
			.z_i      (z_c[i]),
			.range_i  (range_c[i]),
			.ctl_s1   (ctl_c[i+1]),
			.x_s1     (x_c[i+1]),
			.y_s1     (y_c[i+1]),
			.z_s1     (z_c[i+1]),
			.range_s1 (range_c[i+1])
		);
	end

	// residual angle of the last cell is not needed
	spc_scale #(
		.RANGE_BITS (RANGE_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_i       (ctl_c[N]),
		.x_i         (x_c[N]),
		.y_i         (y_c[N]),
		.range_i     (range_c[N]),
		.out_valid_q (out_valid),
		.x_coord_q   (points.x_coord),
		.y_coord_q   (points.y_coord)
	);

	logic z_last_unused;
	assign z_last_unused = ^z_c[N];

endmodule
